@@ sv/awvc_pkg.sv @@
package awvc_pkg;

   // Default sizes of the label set and of each label's score ring.
   localparam int DefMaxLabels = 16;
   localparam int DefMaxWindow = 16;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MIN_SCORE       = 3'd0;
   localparam logic [2:0] CSR_WINDOW_FRAMES   = 3'd1;
   localparam logic [2:0] CSR_MAJORITY        = 3'd2;
   localparam logic [2:0] CSR_NUM_LABELS      = 3'd3;
   localparam logic [2:0] CSR_SKIP_BACKGROUND = 3'd4;

   // Register reset values.
   localparam logic [7:0] RST_MIN_SCORE = 8'd128;
   localparam logic [4:0] RST_WINDOW    = 5'd8;
   localparam logic [4:0] RST_MAJORITY  = 5'd5;
   localparam logic [4:0] RST_LABELS    = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPD,
      ST_CLR,
      ST_PREP,
      ST_SCAN,
      ST_WAIT,
      ST_CHK,
      ST_DIV,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_ready;
      logic lab_clear;
      logic lab_next;
      logic ring_ins;
      logic clr_step;
      logic clr_done;
      logic k_clear;
      logic rd_issue;
      logic acc_clear;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_done;
      logic lab_last;
      logic lab_present;
      logic lab_credited;
      logic clr_last;
      logic rd_last;
      logic qualify;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

@@ sv/awvc_ram.sv @@
module awvc_ram
   #(parameter int Width = 8,
     parameter int Depth = 256)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/awvc_ctrl.sv @@
module awvc_ctrl
   import awvc_pkg::*;
   (input  logic      clock,
    input  logic      reset,
    input  sts_type   sts,
    output cmd_type   cmd,
    output state_type state);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (sts.frame_done) state_in = ST_UPD;
         ST_UPD: begin
            if (sts.lab_credited && !sts.lab_present) state_in = ST_CLR;
            else if (sts.lab_last)                    state_in = ST_PREP;
         end
         ST_CLR: begin
            if (sts.clr_last) state_in = sts.lab_last ? ST_PREP : ST_UPD;
         end
         ST_PREP: begin
            if (sts.lab_present)   state_in = ST_SCAN;
            else if (sts.lab_last) state_in = ST_OUT;
         end
         ST_SCAN: if (sts.rd_last) state_in = ST_WAIT;
         ST_WAIT: state_in = ST_CHK;
         ST_CHK: begin
            if (sts.qualify)       state_in = ST_DIV;
            else if (sts.lab_last) state_in = ST_OUT;
            else                   state_in = ST_PREP;
         end
         ST_DIV: if (sts.div_last) state_in = ST_OUT;
         ST_OUT: if (sts.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.lab_clear = sts.frame_done;
         end
         ST_UPD: begin
            if (sts.lab_credited && !sts.lab_present) begin
               cmd.k_clear = 1'b1;
            end else begin
               cmd.ring_ins  = sts.lab_present;
               cmd.lab_clear = sts.lab_last;
               cmd.lab_next  = !sts.lab_last;
            end
         end
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               cmd.clr_done  = 1'b1;
               cmd.lab_clear = sts.lab_last;
               cmd.lab_next  = !sts.lab_last;
            end
         end
         ST_PREP: begin
            if (sts.lab_present) begin
               cmd.k_clear   = 1'b1;
               cmd.acc_clear = 1'b1;
            end else begin
               cmd.lab_next = !sts.lab_last;
            end
         end
         ST_SCAN: cmd.rd_issue = 1'b1;
         ST_WAIT: cmd = '0;
         ST_CHK: begin
            cmd.div_start = sts.qualify;
            cmd.lab_next  = !sts.qualify && !sts.lab_last;
         end
         ST_DIV: cmd.div_step = 1'b1;
         ST_OUT: cmd.out_load = sts.out_free;
         default: cmd = '0;
      endcase
   end

   assign state = state_ff;

endmodule

@@ sv/awvc_dp.sv @@
module awvc_dp
   import awvc_pkg::*;
   #(parameter int MaxLabels = DefMaxLabels,
     parameter int MaxWindow = DefMaxWindow)
   (input  logic        clock,
    input  logic        reset,
    input  cmd_type     cmd,
    output sts_type     sts,
    input  logic        req_tvalid,
    input  logic [39:0] req_tdata,
    input  logic        req_tlast,
    output logic        req_tready,
    output logic        rsp_tvalid,
    output logic [55:0] rsp_tdata,
    output logic [0:0]  rsp_tuser,
    input  logic        rsp_tready,
    input  logic        csr_valid,
    input  logic [2:0]  csr_index,
    input  logic [7:0]  csr_data,
    output logic        csr_ready);

   localparam int LabW  = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;
   localparam int LcW   = $clog2(MaxLabels + 1);
   localparam int KW    = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
   localparam int CntW  = $clog2(MaxWindow + 1);
   localparam int SumW  = 8 + CntW;
   localparam int Depth = MaxLabels * MaxWindow;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CmpW  = (CntW > 5) ? CntW : 5;
   localparam int LcmW  = (LcW > 5) ? LcW : 5;
   localparam int DcW   = $clog2(SumW + 1);

   // Configuration registers.
   logic [7:0] min_score_ff;
   logic [4:0] window_ff, majority_ff, labels_ff;
   logic       skip_bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_score_ff <= RST_MIN_SCORE;
         window_ff    <= RST_WINDOW;
         majority_ff  <= RST_MAJORITY;
         labels_ff    <= RST_LABELS;
         skip_bg_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_SCORE:       min_score_ff <= csr_data;
            CSR_WINDOW_FRAMES:   window_ff    <= csr_data[4:0];
            CSR_MAJORITY:        majority_ff  <= csr_data[4:0];
            CSR_NUM_LABELS:      labels_ff    <= csr_data[4:0];
            CSR_SKIP_BACKGROUND: skip_bg_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // Effective window length, clamped to 1..MaxWindow.
   logic [CntW-1:0] win_eff;
   always_comb begin
      if (window_ff == 5'd0) begin
         win_eff = CntW'(1);
      end else if (CmpW'(window_ff) > CmpW'(MaxWindow)) begin
         win_eff = CntW'(MaxWindow);
      end else begin
         win_eff = CntW'(window_ff);
      end
   end

   // Argmax over the scores of one frame.
   logic [7:0]     score;
   logic           req_acc;
   logic [7:0]     best_ff;
   logic           best_vld_ff;
   logic [LabW-1:0] best_lab_ff;
   logic [LcW-1:0] lcnt_ff;
   logic [31:0]    stamp_ff;
   logic           in_range;
   logic [7:0]     bar;

   assign score      = req_tdata[7:0];
   assign req_tready = cmd.req_ready;
   assign req_acc    = req_tvalid && cmd.req_ready;
   assign in_range   = (LcmW'(lcnt_ff) < LcmW'(labels_ff)) &&
                       (lcnt_ff < LcW'(MaxLabels));
   assign bar        = best_vld_ff ? best_ff : min_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
         lcnt_ff     <= '0;
      end else begin
         if (req_acc) begin
            if (in_range && score > bar) begin
               best_vld_ff <= 1'b1;
               best_ff     <= score;
               best_lab_ff <= lcnt_ff[LabW-1:0];
            end
            if (req_tlast) begin
               lcnt_ff  <= '0;
               stamp_ff <= req_tdata[39:8];
            end else if (lcnt_ff < LcW'(MaxLabels)) begin
               lcnt_ff <= lcnt_ff + LcW'(1);
            end
         end
         if (cmd.out_load) begin
            best_vld_ff <= 1'b0;
            best_ff     <= '0;
         end
      end
   end

   // Label and entry counters, ring bookkeeping.
   logic [LabW-1:0] lab_ff;
   logic [KW-1:0]   k_ff;
   logic [KW-1:0]   pos_ff [MaxLabels];
   logic [MaxLabels-1:0] present_ff;
   logic            credited;
   logic [KW:0]     p_inc;
   logic [KW-1:0]   p_new;

   assign credited = best_vld_ff && (best_lab_ff == lab_ff) &&
                     !(best_lab_ff == '0 && skip_bg_ff);
   assign p_inc    = {1'b0, pos_ff[lab_ff]} + (KW+1)'(1);
   assign p_new    = ((KW+1 > CntW ? (KW+1) : CntW)'(p_inc) >=
                      (KW+1 > CntW ? (KW+1) : CntW)'(win_eff)) ? '0 : p_inc[KW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         lab_ff     <= '0;
         k_ff       <= '0;
      end else begin
         if (cmd.lab_clear)     lab_ff <= '0;
         else if (cmd.lab_next) lab_ff <= lab_ff + LabW'(1);
         if (cmd.k_clear)                          k_ff <= '0;
         else if (cmd.clr_step || cmd.rd_issue)    k_ff <= k_ff + KW'(1);
         if (cmd.clr_done) present_ff[lab_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_done)      pos_ff[lab_ff] <= '0;
      else if (cmd.ring_ins) pos_ff[lab_ff] <= p_new;
   end

   // Score ring storage.
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr, base;
   logic [7:0]    wr_data, rd_data;

   assign base    = AW'(AW'(lab_ff) * AW'(MaxWindow));
   assign wr_en   = cmd.ring_ins || cmd.clr_step;
   assign wr_addr = base + AW'(cmd.clr_step ? k_ff : p_new);
   assign rd_addr = base + AW'(k_ff);
   always_comb begin
      if (cmd.clr_step) wr_data = (k_ff == '0) ? best_ff : 8'd0;
      else              wr_data = credited ? best_ff : 8'd0;
   end

   awvc_ram #(.Width(8), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data));

   // Count and sum of the above-threshold entries of one ring.
   logic            rd_vld_ff;
   logic [CntW-1:0] cnt_ff;
   logic [SumW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (rd_vld_ff && rd_data > min_score_ff) begin
         cnt_ff <= cnt_ff + CntW'(1);
         sum_ff <= sum_ff + SumW'(rd_data);
      end
   end

   // Restoring divider, one quotient bit a cycle.
   logic [SumW-1:0] quo_ff;
   logic [CntW:0]   rem_ff;
   logic [DcW-1:0]  dcnt_ff;
   logic            hit_ff;
   logic [CntW:0]   rem_sh;

   assign rem_sh = {rem_ff[CntW-1:0], quo_ff[SumW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.lab_clear) begin
         hit_ff <= 1'b0;
      end else if (cmd.div_start) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= sum_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DcW'(1);
         if (rem_sh >= {1'b0, cnt_ff}) begin
            rem_ff <= rem_sh - {1'b0, cnt_ff};
            quo_ff <= {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[SumW-2:0], 1'b0};
         end
      end
   end

   // Result register.
   logic        rsp_vld_ff;
   logic [55:0] rsp_data_ff;
   logic        rsp_det_ff;
   logic [7:0]  avg;

   assign avg = (cnt_ff == '0) ? 8'd0 : quo_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_det_ff <= hit_ff;
         if (hit_ff) begin
            rsp_data_ff <= {7'd0, stamp_ff, 5'(cnt_ff), avg, 4'(lab_ff)};
         end else begin
            rsp_data_ff <= {7'd0, stamp_ff, 17'd0};
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_det_ff;

   // Status to the controller.
   always_comb begin
      sts.frame_done   = req_acc && req_tlast;
      sts.lab_last     = (lab_ff == LabW'(MaxLabels - 1));
      sts.lab_present  = present_ff[lab_ff];
      sts.lab_credited = credited;
      sts.clr_last     = (k_ff == KW'(MaxWindow - 1));
      sts.rd_last      = ((CntW'(k_ff) + CntW'(1)) == win_eff);
      sts.qualify      = (CmpW'(cnt_ff) >= CmpW'(majority_ff));
      sts.div_last     = (dcnt_ff == DcW'(SumW - 1));
      sts.out_free     = !rsp_vld_ff || rsp_tready;
   end

endmodule

@@ sv/argmax_window_vote_classifier.sv @@
// Argmax classifier with a per-label sliding-window vote. Scores arrive one
// per req transaction in label order, with tlast on the last score of a
// frame; scores are taken while the block is idle. On the frame's last score
// the block stops taking scores, credits the winning label's ring (a new
// ring is swept clear, with the score as its first entry), ages every other
// present ring with a zero, then scans the present rings in label order,
// reading one ring entry a cycle from a score memory with one write port and
// one registered read port, and divides the first qualifying ring's sum by
// its count with a restoring divider at one bit a cycle; the quotient has
// SumW = 8 + clog2(MaxWindow + 1) bits. Exactly one rsp transaction is made
// per frame; rsp_tuser is 1 on a detection. Configuration must be written
// only while no frame is in progress; the block itself does not enforce this.
module argmax_window_vote_classifier
   import awvc_pkg::*;
   #(parameter int MaxLabels = DefMaxLabels,
     parameter int MaxWindow = DefMaxWindow)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_tvalid,
    output logic        req_tready,
    input  logic [39:0] req_tdata,   // class_score[7:0], frame_stamp[39:8]
    input  logic        req_tlast,
    output logic        rsp_tvalid,
    input  logic        rsp_tready,
    // found_label[3:0], avg_score[11:4], above_count[16:12],
    // detect_stamp[48:17], zero fill above
    output logic [55:0] rsp_tdata,
    output logic [0:0]  rsp_tuser,   // detected[0]
    input  logic        csr_valid,
    output logic        csr_ready,
    input  logic [2:0]  csr_index,
    input  logic [7:0]  csr_data);

   cmd_type   cmd;
   sts_type   sts;
   state_type state;

   awvc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd),
      .state (state));

   awvc_dp #(.MaxLabels(MaxLabels), .MaxWindow(MaxWindow)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_ready  (csr_ready));

`ifndef ASSERT_OFF
   // After a frame's last score the block is busy with the ring update.
   a_busy_after_frame: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("score taken right after frame end");

   // A result without detection carries only the stamp.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[16:0] == 17'd0)
      else $error("non-detection result has nonzero fields");

   // A result is only presented once the controller reaches the output step.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state) == ST_OUT)
      else $error("result appeared outside the output step");
`endif

endmodule
